// ===== rtl/gpsfd_pkg.sv =====
// Package with the constants and types shared by the gamepad frame decoder.
`timescale 1ns / 1ps

package gpsfd_pkg;

    localparam int FrameLen = 10;
    localparam int DataLen = FrameLen - 1;
    localparam int CountW = 4;

    localparam logic [7:0] NewlineChar = 8'h0A;
    localparam logic [7:0] CharOffset = 8'h20;
    localparam logic [7:0] LastCharMax = 8'h5F;
    localparam logic [7:0] AxisCentre = 8'd127;
    localparam logic [CountW-1:0] CountMax = 4'd15;
    localparam logic [CountW-1:0] CountFrame = 4'd10;
    localparam logic [CountW-1:0] CountData = 4'd9;

    typedef logic [DataLen-1:0][7:0] t_frame_bytes;

    typedef struct packed {
        logic [15:0] buttons;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
    } t_frame_vals;

endpackage

// ===== rtl/gpsfd_unpack.sv =====
// Unpacks the nine data bytes of a frame into the button word and stick axes.
`timescale 1ns / 1ps

module gpsfd_unpack (
    input  gpsfd_pkg::t_frame_bytes i_bytes,
    output gpsfd_pkg::t_frame_vals  o_vals
);
    import gpsfd_pkg::*;

    logic [DataLen-1:0][7:0] m;

    always_comb begin
        for (int i = 0; i < DataLen; i++) begin
            m[i] = i_bytes[i] - CharOffset;
        end
    end

    assign o_vals.buttons = {m[2][3:0], m[1][5:0], m[0][5:0]};
    assign o_vals.left_x  = {m[4][1:0], 6'b0} | m[3];
    assign o_vals.left_y  = {m[5][3:0], m[4][5:2]};
    assign o_vals.right_x = {m[6][5:0], m[5][5:4]};
    assign o_vals.right_y = {m[8][1:0], 6'b0} | m[7];

endmodule

// ===== rtl/gamepad_serial_frame_decoder.sv =====
// Top level of the gamepad serial frame decoder.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_rx_byte
// result    out        o_out_valid / i_out_stall  o_frame_ok .. o_activity_led
//
// One byte can be accepted in every cycle while o_in_stall is low; a byte passes an
// input register and then updates the frame state, where a newline also loads its
// result into the output registers, from which it can then be taken.
// A byte other than a newline never waits on the result side.
// A newline waits in the input register only while an earlier result is stalled.
// Reset is synchronous and active low and restores the idle stick and button state.

module gamepad_serial_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_frame_ok,
    output logic [15:0] o_buttons,
    output logic [7:0]  o_joy_left_x,
    output logic [7:0]  o_joy_left_y,
    output logic [7:0]  o_joy_right_x,
    output logic [7:0]  o_joy_right_y,
    output logic [15:0] o_pressed_mask,
    output logic [15:0] o_released_mask,
    output logic [15:0] o_held_mask,
    output logic        o_activity_led
);
    import gpsfd_pkg::*;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic [7:0]        r_store [FrameLen];
    logic [CountW-1:0] r_count;
    logic [5:0]        r_sum;
    logic [15:0]       r_buttons;
    logic [15:0]       r_prev;
    logic [7:0]        r_axis [4];
    logic              r_led;
    logic              r_out_valid;

    logic              n_in_valid;
    logic [CountW-1:0] n_count;
    logic [5:0]        n_sum;
    logic [15:0]       n_buttons;
    logic [15:0]       n_prev;
    logic [7:0]        n_axis [4];
    logic              n_led;
    logic              n_out_valid;

    logic         is_newline;
    logic         proc_go;
    logic         frame_ok;
    logic [7:0]   last_m;
    t_frame_bytes data_bytes;
    t_frame_vals  vals;

    always_comb begin
        for (int i = 0; i < DataLen; i++) begin
            data_bytes[i] = r_store[i];
        end
    end

    gpsfd_unpack u_unpack (
        .i_bytes (data_bytes),
        .o_vals  (vals)
    );

    assign is_newline = (r_in_byte == NewlineChar);
    assign proc_go    = r_in_valid && (!is_newline || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proc_go;
    assign n_in_valid = (i_in_valid && !o_in_stall) || (r_in_valid && !proc_go);

    assign last_m   = r_store[FrameLen-1] - CharOffset;
    assign frame_ok = (r_count == CountFrame) && (r_store[FrameLen-1] >= CharOffset)
                      && (r_store[FrameLen-1] <= LastCharMax) && (last_m[5:0] == r_sum);

    always_comb begin
        n_count   = r_count;
        n_sum     = r_sum;
        n_buttons = r_buttons;
        n_prev    = r_prev;
        n_axis    = r_axis;
        n_led     = r_led;
        if (proc_go) begin
            if (is_newline) begin
                n_count = '0;
                n_sum   = '0;
                if (frame_ok) begin
                    n_prev    = r_buttons;
                    n_buttons = vals.buttons;
                    n_axis[0] = vals.left_x;
                    n_axis[1] = vals.left_y;
                    n_axis[2] = vals.right_x;
                    n_axis[3] = vals.right_y;
                    n_led     = !r_led;
                end
            end else begin
                if (r_count < CountData) begin
                    n_sum = r_sum + 6'(r_in_byte - CharOffset);
                end
                if (r_count < CountMax) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    assign n_out_valid = (proc_go && is_newline) || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_count     <= '0;
            r_sum       <= '0;
            r_buttons   <= '0;
            r_prev      <= '0;
            r_axis      <= '{AxisCentre, AxisCentre, AxisCentre, AxisCentre};
            r_led       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_buttons   <= n_buttons;
            r_prev      <= n_prev;
            r_axis      <= n_axis;
            r_led       <= n_led;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
        if (proc_go && !is_newline && (r_count < CountFrame)) begin
            r_store[r_count] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && is_newline) begin
            o_frame_ok      <= frame_ok;
            o_buttons       <= n_buttons;
            o_joy_left_x    <= n_axis[0];
            o_joy_left_y    <= n_axis[1];
            o_joy_right_x   <= n_axis[2];
            o_joy_right_y   <= n_axis[3];
            o_pressed_mask  <= n_buttons & ~n_prev;
            o_released_mask <= ~n_buttons & n_prev;
            o_held_mask     <= n_buttons & n_prev;
            o_activity_led  <= n_led;
        end
    end

    assign o_out_valid = r_out_valid;

    a_newline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && is_newline |=> (r_count == '0) && (r_sum == '0))
        else $error("Count or checksum not cleared after a newline.");

    a_ok_toggles_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && is_newline && frame_ok |=> r_led != $past(r_led))
        else $error("Activity LED did not toggle on a good frame.");

    a_bad_keeps_buttons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && is_newline && !frame_ok |=> $stable(r_buttons) && $stable(r_prev))
        else $error("Button state changed on a rejected frame.");

    a_result_matches_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_activity_led == r_led)
        else $error("Pending result disagrees with the LED state.");

endmodule

// ===== tb/tb_gamepad_serial_frame_decoder.sv =====
// Self-checking testbench for the gamepad serial frame decoder.
`timescale 1ns / 1ps

import gpsfd_pkg::*;

typedef struct packed {
    logic        frame_ok;
    logic [15:0] buttons;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [15:0] pressed;
    logic [15:0] released;
    logic [15:0] held;
    logic        led;
} pad_report_t;

class pad_frame_checker;
    logic [7:0]  line_bytes[FrameLen];
    logic [3:0]  line_len;
    logic [5:0]  line_sum;
    logic [15:0] btn_now;
    logic [15:0] btn_prev;
    logic [7:0]  axis[4];
    logic        led;
    pad_report_t due_reports[$];
    int          errors;

    function new();
        foreach (line_bytes[i]) line_bytes[i] = 8'h00;
        line_len = '0;
        line_sum = '0;
        btn_now = '0;
        btn_prev = '0;
        foreach (axis[i]) axis[i] = AxisCentre;
        led = 1'b0;
        errors = 0;
    endfunction

    function void note_byte(logic [7:0] c);
        logic [7:0]  m[DataLen];
        logic [7:0]  d;
        logic [7:0]  last;
        logic        good;
        pad_report_t r;
        if (c != NewlineChar) begin
            if (line_len < CountFrame) begin
                line_bytes[line_len] = c;
                if (line_len < CountData) begin
                    d = c - CharOffset;
                    line_sum = line_sum + d[5:0];
                end
            end
            if (line_len < CountMax) line_len++;
            return;
        end
        good = 1'b0;
        if (line_len == CountFrame) begin
            last = line_bytes[FrameLen-1];
            d = last - CharOffset;
            good = (last >= CharOffset) && (last <= LastCharMax) && (d[5:0] == line_sum);
        end
        if (good) begin
            foreach (m[i]) m[i] = line_bytes[i] - CharOffset;
            btn_prev = btn_now;
            btn_now = {m[2][3:0], m[1][5:0], m[0][5:0]};
            axis[0] = m[3] | {m[4][1:0], 6'b0};
            axis[1] = {m[5][3:0], m[4][5:2]};
            axis[2] = {m[6][5:0], m[5][5:4]};
            axis[3] = m[7] | {m[8][1:0], 6'b0};
            led = ~led;
        end
        line_len = '0;
        line_sum = '0;
        r.frame_ok = good;
        r.buttons = btn_now;
        r.left_x = axis[0];
        r.left_y = axis[1];
        r.right_x = axis[2];
        r.right_y = axis[3];
        r.pressed = btn_now & ~btn_prev;
        r.released = ~btn_now & btn_prev;
        r.held = btn_now & btn_prev;
        r.led = led;
        due_reports.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned seen);
        if (want != seen) begin
            $display("%0t: %s expected %0h, actual %0h", $time, field, want, seen);
            errors++;
        end
    endfunction

    function void check_result(pad_report_t got);
        pad_report_t want;
        if (due_reports.size() == 0) begin
            $display("%0t: result expected none, actual %0h", $time, got);
            errors++;
            return;
        end
        want = due_reports.pop_front();
        compare_field("frame_ok", want.frame_ok, got.frame_ok);
        compare_field("buttons", want.buttons, got.buttons);
        compare_field("joy_left_x", want.left_x, got.left_x);
        compare_field("joy_left_y", want.left_y, got.left_y);
        compare_field("joy_right_x", want.right_x, got.right_x);
        compare_field("joy_right_y", want.right_y, got.right_y);
        compare_field("pressed_mask", want.pressed, got.pressed);
        compare_field("released_mask", want.released, got.released);
        compare_field("held_mask", want.held, got.held);
        compare_field("activity_led", want.led, got.led);
    endfunction
endclass

module tb_gamepad_serial_frame_decoder;

    typedef enum int {
        LineGood,
        LineBadSum,
        LineBadRange,
        LineShort,
        LineLong,
        LineNoise
    } line_kind_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_frame_ok;
    logic [15:0] o_buttons;
    logic [7:0]  o_joy_left_x;
    logic [7:0]  o_joy_left_y;
    logic [7:0]  o_joy_right_x;
    logic [7:0]  o_joy_right_y;
    logic [15:0] o_pressed_mask;
    logic [15:0] o_released_mask;
    logic [15:0] o_held_mask;
    logic        o_activity_led;

    pad_frame_checker sb = new();
    int sent_bytes = 0;
    int in_calm = 0;
    int out_calm = 0;
    int stall_left = 0;
    int out_taken = 0;
    int out_seen = 0;

    gamepad_serial_frame_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_frame_ok      (o_frame_ok),
        .o_buttons       (o_buttons),
        .o_joy_left_x    (o_joy_left_x),
        .o_joy_left_y    (o_joy_left_y),
        .o_joy_right_x   (o_joy_right_x),
        .o_joy_right_y   (o_joy_right_y),
        .o_pressed_mask  (o_pressed_mask),
        .o_released_mask (o_released_mask),
        .o_held_mask     (o_held_mask),
        .o_activity_led  (o_activity_led)
    );

    always #5 i_clk = ~i_clk;

    function automatic int draw_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) calm = $urandom_range(8, 40);
        return $urandom_range(0, 12);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait(in_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_byte(b);
        sent_bytes++;
    endtask

    task automatic send_frame(input line_kind_t kind);
        logic [7:0] b;
        logic [7:0] d;
        logic [5:0] s;
        logic [7:0] tenth;
        s = '0;
        repeat (DataLen) begin
            do b = 8'($urandom_range(0, 255)); while (b == NewlineChar);
            d = b - CharOffset;
            s = s + d[5:0];
            send_byte(b);
        end
        tenth = {2'b00, s} + CharOffset;
        if (kind == LineBadSum) begin
            tenth = {2'b00, s ^ 6'($urandom_range(1, 63))} + CharOffset;
        end else if (kind == LineBadRange) begin
            tenth = tenth + 8'(64 * $urandom_range(1, 3));
            if (tenth == NewlineChar) tenth = 8'h6A;
        end
        send_byte(tenth);
        send_byte(NewlineChar);
    endtask

    task automatic send_plain_line(input int len);
        logic [7:0] b;
        repeat (len) begin
            do b = 8'($urandom_range(0, 255)); while (b == NewlineChar);
            send_byte(b);
        end
        send_byte(NewlineChar);
    endtask

    always @(negedge i_clk) begin
        if (out_taken != out_seen) begin
            out_seen = out_taken;
            stall_left = draw_wait(out_calm);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : watch_results
        pad_report_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.frame_ok = o_frame_ok;
            got.buttons = o_buttons;
            got.left_x = o_joy_left_x;
            got.left_y = o_joy_left_y;
            got.right_x = o_joy_right_x;
            got.right_y = o_joy_right_y;
            got.pressed = o_pressed_mask;
            got.released = o_released_mask;
            got.held = o_held_mask;
            got.led = o_activity_led;
            sb.check_result(got);
            out_taken++;
        end
    end

    initial begin
        #(2_000_000);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int pick;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All data fields at their maximum.
        repeat (DataLen) send_byte(8'h5F);
        send_byte(8'h57);
        send_byte(NewlineChar);
        // Empty line and a short line with extreme byte values.
        send_byte(NewlineChar);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(NewlineChar);
        // Checksum byte above range whose low six bits still match.
        repeat (DataLen) send_byte(CharOffset);
        send_byte(8'h60);
        send_byte(NewlineChar);

        while (sent_bytes < 650) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) send_frame(LineGood);
            else if (pick < 75) send_frame(LineBadSum);
            else if (pick < 82) send_frame(LineBadRange);
            else if (pick < 88) send_plain_line($urandom_range(0, DataLen));
            else if (pick < 94) send_plain_line($urandom_range(FrameLen + 1, 20));
            else repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (sb.due_reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gpsfd_pkg.sv
rtl/gpsfd_unpack.sv
rtl/gamepad_serial_frame_decoder.sv
tb/tb_gamepad_serial_frame_decoder.sv
